// File: sv/swo_pkg.sv
// Shared types and constants for the sliced wavetable oscillator.
// No dependencies; used by swo_mul and sliced_wavetable_oscillator.
package swo_pkg;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_SLICE  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] CFG_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_SPAN    = 2'd1;
  localparam logic [1:0] CFG_LENGTH  = 2'd2;
  localparam logic [1:0] CFG_SLICES  = 2'd3;

  localparam logic [31:0] PERIOD_RST = 32'd89478;
  localparam logic [4:0]  SPAN_RST   = 5'd10;

  localparam logic [15:0] SELECT_MAX = 16'd65529;
  localparam logic [17:0] EXP_C0     = 18'd5156;
  localparam logic [17:0] EXP_C1     = 18'd14821;
  localparam logic [17:0] EXP_C2     = 18'd45559;
  localparam logic [17:0] ONE_Q16    = 18'd65536;
  localparam logic [21:0] EXP_BIAS   = 22'h100000;

  localparam int unsigned MUL_STEPS  = 32;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [95:0] prod;
  } mul_rsp_t;

endpackage

// File: sv/swo_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on swo_pkg for the request and response structs.
module swo_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  swo_pkg::mul_req_t req,
  output swo_pkg::mul_rsp_t rsp
);
  import swo_pkg::*;

  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [95:0] p_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] sum;

  assign sum = {1'b0, p_r[95:32]} + (b_r[0] ? {1'b0, a_r} : 65'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= {sum, p_r[31:1]};
      b_r <= {1'b0, b_r[31:1]};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = p_r;

endmodule

// File: sv/sliced_wavetable_oscillator.sv
// Sliced wavetable oscillator: phase accumulator, exp2 pitch, interpolated lookup.
// Depends on swo_pkg and swo_mul.
// A load request gives its zero result in the cycle after acceptance. A tick (with a
// nonzero sample length) runs through one shared bit-serial multiplier: nine products
// from acceptance to result with zero or one slice and fifteen with two or more, plus
// an extra ST_WRAP pass per wrap of a slice address past the sample depth. No new
// request is taken while a result waits. Memories need no clearing after reset.
module sliced_wavetable_oscillator #(
  parameter int SAMPLE_DEPTH = 16384,
  parameter int SLICE_DEPTH  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [15:0] in_pitch,
  input  logic [31:0]        in_fundamental,
  input  logic               in_sync,
  input  logic [31:0]        in_phase_offset,
  input  logic [15:0]        in_slice_select,
  input  logic [13:0]        in_load_address,
  input  logic signed [15:0] in_load_sample,
  input  logic [13:0]        in_load_start,
  input  logic [14:0]        in_load_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out,
  output logic [13:0]        out_read_position,
  output logic [5:0]         out_active_slice,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import swo_pkg::*;

  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int SLW = $clog2(SLICE_DEPTH);
  localparam int CW  = $clog2(SLICE_DEPTH + 1);
  localparam int SW  = ((AW > 14) ? AW : 14) + 1;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SPAN = 5'd1;
  localparam logic [4:0] ST_EXP1 = 5'd2;
  localparam logic [4:0] ST_EXP2 = 5'd3;
  localparam logic [4:0] ST_EXP3 = 5'd4;
  localparam logic [4:0] ST_PER  = 5'd5;
  localparam logic [4:0] ST_INC  = 5'd6;
  localparam logic [4:0] ST_SEL  = 5'd7;
  localparam logic [4:0] ST_TAB  = 5'd8;
  localparam logic [4:0] ST_LGO  = 5'd9;
  localparam logic [4:0] ST_LOC  = 5'd10;
  localparam logic [4:0] ST_WRAP = 5'd11;
  localparam logic [4:0] ST_RD0  = 5'd12;
  localparam logic [4:0] ST_RD1  = 5'd13;
  localparam logic [4:0] ST_RD2  = 5'd14;
  localparam logic [4:0] ST_LA   = 5'd15;
  localparam logic [4:0] ST_LB   = 5'd16;
  localparam logic [4:0] ST_BA   = 5'd17;
  localparam logic [4:0] ST_BB   = 5'd18;

  logic [31:0] period_r;
  logic [4:0]  span_r;
  logic [14:0] slen_r;
  logic [6:0]  scount_r;

  logic [4:0]  state_r;
  logic [31:0] acc_r;
  logic [31:0] fund_r;
  logic        sync_r;
  logic [31:0] offset_r;
  logic [15:0] sel_r;
  logic [6:0]  s_r;
  logic [14:0] f_r;
  logic [17:0] t_r;
  logic [31:0] q_r;
  logic [SLW-1:0] slice_r;
  logic        upper_r;
  logic        two_r;
  logic        use_tab_r;
  logic [15:0] ws_r;
  logic [13:0] start_r;
  logic [15:0] w_r;
  logic [SW-1:0] addr_r;
  logic [AW-1:0] first_r;
  logic signed [15:0] s0_r;
  logic signed [15:0] s1_r;
  logic [63:0] lsum_r;
  logic [63:0] asum_r;

  logic               out_valid_r;
  logic signed [15:0] out_sample_r;
  logic [13:0]        out_pos_r;
  logic [5:0]         out_slice_r;

  logic signed [15:0] smem [SAMPLE_DEPTH];
  logic [13:0]        tstart_mem [SLICE_DEPTH];
  logic [14:0]        tlen_mem [SLICE_DEPTH];
  logic signed [15:0] rdata_r;
  logic [13:0]        tstart_r;
  logic [14:0]        tlen_r;

  mul_req_t mreq_r;
  mul_rsp_t mrsp;

  swo_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq_r),
    .rsp  (mrsp)
  );

  logic          in_acc;
  logic          smem_we;
  logic          tab_we;
  logic [AW-1:0] addr1;
  logic [AW-1:0] rd_addr;
  logic [SLW-1:0] tab_idx;
  logic [CW-1:0] count;
  logic [21:0]   ue;
  logic [17:0]   t_step;
  logic [95:0]   shifted;
  logic [31:0]   acc_nxt;
  logic [15:0]   sel_clamp;
  logic [31:0]   len_w;
  logic [31:0]   len_c;
  logic [31:0]   n_w;
  logic [13:0]   use_start;
  logic [63:0]   v_lin;
  logic [63:0]   v_bil;
  logic [63:0]   r16;
  logic [63:0]   r32;
  logic [20:0]   first_w;
  logic [10:0]   slice_w;

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign smem_we   = in_acc && (in_mode == MODE_SAMPLE) &&
                     ({18'd0, in_load_address} < 32'(SAMPLE_DEPTH));
  assign tab_we    = in_acc && (in_mode == MODE_SLICE) &&
                     ({18'd0, in_load_address} < 32'(SLICE_DEPTH));

  assign count     = ({25'd0, scount_r} > 32'(SLICE_DEPTH)) ? CW'(SLICE_DEPTH)
                                                           : CW'(scount_r);
  assign ue        = mrsp.prod[21:0] + EXP_BIAS;
  assign t_step    = (state_r == ST_EXP1) ? EXP_C1 + mrsp.prod[31:15]
                                          : EXP_C2 + mrsp.prod[31:15];
  assign shifted   = mrsp.prod >> s_r;
  assign acc_nxt   = sync_r ? 32'd0 : acc_r + shifted[31:0];
  assign sel_clamp = (sel_r > SELECT_MAX) ? SELECT_MAX : sel_r;

  assign len_w     = use_tab_r ? {17'd0, tlen_r} : {17'd0, slen_r};
  assign use_start = use_tab_r ? tstart_r : 14'd0;
  assign len_c     = (len_w > 32'(SAMPLE_DEPTH)) ? 32'(SAMPLE_DEPTH) : len_w;
  assign n_w       = (len_c == 32'd0) ? 32'd0 : len_c - 32'd1;

  assign addr1     = (addr_r == SW'(SAMPLE_DEPTH - 1)) ? '0 : AW'(addr_r + SW'(1));
  assign rd_addr   = (state_r == ST_RD0) ? addr_r[AW-1:0] : addr1;
  assign tab_idx   = slice_r + SLW'(upper_r);

  assign v_lin     = lsum_r + mrsp.prod[63:0];
  assign v_bil     = asum_r + mrsp.prod[63:0];
  assign r16       = v_lin + 64'h8000;
  assign r32       = v_bil + 64'h8000_0000;
  assign first_w   = 21'(first_r);
  assign slice_w   = 11'(slice_r);

  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[AW'(in_load_address)] <= in_load_sample;
    end
    rdata_r <= smem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tstart_mem[in_load_address[SLW-1:0]] <= in_load_start;
      tlen_mem[in_load_address[SLW-1:0]]   <= in_load_length;
    end
    tstart_r <= tstart_mem[tab_idx];
    tlen_r   <= tlen_mem[tab_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      span_r   <= SPAN_RST;
      slen_r   <= '0;
      scount_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PERIOD: period_r <= cfg_data;
        CFG_SPAN:   span_r   <= cfg_data[4:0];
        CFG_LENGTH: slen_r   <= cfg_data[14:0];
        CFG_SLICES: scount_r <= cfg_data[6:0];
        default:    period_r <= period_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
      mreq_r.start <= 1'b0;
    end else begin
      mreq_r.start <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            fund_r   <= in_fundamental;
            sync_r   <= in_sync;
            offset_r <= in_phase_offset;
            sel_r    <= in_slice_select;
            if (in_mode == MODE_TICK && slen_r != 15'd0) begin
              mreq_r.start <= 1'b1;
              mreq_r.a     <= {{48{in_pitch[15]}}, in_pitch};
              mreq_r.b     <= {27'd0, span_r};
              state_r      <= ST_SPAN;
            end else begin
              out_valid_r  <= 1'b1;
              out_sample_r <= '0;
              out_pos_r    <= '0;
              out_slice_r  <= '0;
            end
          end
        end
        ST_SPAN: begin
          if (mrsp.done) begin
            s_r          <= 7'd64 - ue[21:15];
            f_r          <= ue[14:0];
            mreq_r.start <= 1'b1;
            mreq_r.a     <= {46'd0, EXP_C0};
            mreq_r.b     <= {17'd0, ue[14:0]};
            state_r      <= ST_EXP1;
          end
        end
        ST_EXP1, ST_EXP2: begin
          if (mrsp.done) begin
            mreq_r.start <= 1'b1;
            mreq_r.a     <= {46'd0, t_step};
            mreq_r.b     <= {17'd0, f_r};
            state_r      <= (state_r == ST_EXP1) ? ST_EXP2 : ST_EXP3;
          end
        end
        ST_EXP3: begin
          if (mrsp.done) begin
            t_r          <= ONE_Q16 + mrsp.prod[31:15];
            mreq_r.start <= 1'b1;
            mreq_r.a     <= {32'd0, period_r};
            mreq_r.b     <= fund_r;
            state_r      <= ST_PER;
          end
        end
        ST_PER: begin
          if (mrsp.done) begin
            mreq_r.start <= 1'b1;
            mreq_r.a     <= mrsp.prod[63:0];
            mreq_r.b     <= {14'd0, t_r};
            state_r      <= ST_INC;
          end
        end
        ST_INC: begin
          if (mrsp.done) begin
            acc_r     <= acc_nxt;
            q_r       <= acc_nxt + offset_r;
            slice_r   <= '0;
            upper_r   <= 1'b0;
            use_tab_r <= (count != '0);
            two_r     <= (count > CW'(1));
            if (count > CW'(1)) begin
              mreq_r.start <= 1'b1;
              mreq_r.a     <= {48'd0, sel_clamp};
              mreq_r.b     <= 32'(count - CW'(1));
              state_r      <= ST_SEL;
            end else begin
              state_r <= ST_TAB;
            end
          end
        end
        ST_SEL: begin
          if (mrsp.done) begin
            slice_r <= mrsp.prod[16 +: SLW];
            ws_r    <= mrsp.prod[15:0];
            state_r <= ST_TAB;
          end
        end
        ST_TAB: begin
          state_r <= ST_LGO;
        end
        ST_LGO: begin
          start_r      <= use_start;
          mreq_r.start <= 1'b1;
          mreq_r.a     <= {32'd0, q_r};
          mreq_r.b     <= n_w;
          state_r      <= ST_LOC;
        end
        ST_LOC: begin
          if (mrsp.done) begin
            w_r     <= mrsp.prod[31:16];
            addr_r  <= SW'(start_r) + SW'(mrsp.prod[32 +: AW]);
            state_r <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (addr_r >= SW'(SAMPLE_DEPTH)) begin
            addr_r <= addr_r - SW'(SAMPLE_DEPTH);
          end else begin
            if (!upper_r) begin
              first_r <= addr_r[AW-1:0];
            end
            state_r <= ST_RD0;
          end
        end
        ST_RD0: begin
          state_r <= ST_RD1;
        end
        ST_RD1: begin
          s0_r    <= rdata_r;
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          s1_r         <= rdata_r;
          mreq_r.start <= 1'b1;
          mreq_r.a     <= {{48{s0_r[15]}}, s0_r};
          mreq_r.b     <= 32'h1_0000 - {16'd0, w_r};
          state_r      <= ST_LA;
        end
        ST_LA: begin
          if (mrsp.done) begin
            lsum_r       <= mrsp.prod[63:0];
            mreq_r.start <= 1'b1;
            mreq_r.a     <= {{48{s1_r[15]}}, s1_r};
            mreq_r.b     <= {16'd0, w_r};
            state_r      <= ST_LB;
          end
        end
        ST_LB: begin
          if (mrsp.done) begin
            if (!two_r) begin
              out_valid_r  <= 1'b1;
              out_sample_r <= r16[31:16];
              out_pos_r    <= first_w[13:0];
              out_slice_r  <= slice_w[5:0];
              state_r      <= ST_IDLE;
            end else if (!upper_r) begin
              asum_r  <= v_lin;
              upper_r <= 1'b1;
              state_r <= ST_TAB;
            end else begin
              lsum_r       <= v_lin;
              mreq_r.start <= 1'b1;
              mreq_r.a     <= asum_r;
              mreq_r.b     <= 32'h1_0000 - {16'd0, ws_r};
              state_r      <= ST_BA;
            end
          end
        end
        ST_BA: begin
          if (mrsp.done) begin
            asum_r       <= mrsp.prod[63:0];
            mreq_r.start <= 1'b1;
            mreq_r.a     <= lsum_r;
            mreq_r.b     <= {16'd0, ws_r};
            state_r      <= ST_BB;
          end
        end
        ST_BB: begin
          if (mrsp.done) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= r32[47:32];
            out_pos_r    <= first_w[13:0];
            out_slice_r  <= slice_w[5:0];
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_read_position = out_pos_r;
  assign out_active_slice  = out_slice_r;

`ifndef SYNTHESIS
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mreq_r.start |-> !mrsp.busy)
    else $error("multiplier started while busy");

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_TICK && slen_r == 15'd0) |=>
      (out_valid && out_sample_out == 16'sd0 && $stable(acc_r)))
    else $error("silent tick gave a non-zero result or moved the phase");

  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_SAMPLE || in_mode == MODE_SLICE)) |=>
      (out_valid && out_sample_out == 16'sd0 && out_read_position == 14'd0))
    else $error("load request result not zero");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_INC) |=> $stable(acc_r))
    else $error("phase moved outside the increment step");
`endif

endmodule

// File: tb/tb.sv
// Self-checking bench for sliced_wavetable_oscillator: directed table, then random phases.
// Depends on swo_pkg and the oscillator RTL; carries its own bit-exact oscillator predictor.
module tb;
  import swo_pkg::*;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] pitch;
    logic [31:0]        fund;
    logic               sync;
    logic [31:0]        offs;
    logic [15:0]        sel;
    logic [13:0]        addr;
    logic signed [15:0] smp;
    logic [13:0]        start;
    logic [14:0]        len;
  } osc_req_t;

  typedef struct packed {
    logic signed [15:0] smp;
    logic [13:0]        pos;
    logic [5:0]         slc;
  } osc_res_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_FILL} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_dat;
    osc_req_t    req;
    logic        typed;
    osc_res_t    res;
  } plan_row_t;

  localparam osc_res_t ZERO_RES   = '0;
  localparam int       N_RANDOM   = 680;
  localparam int       FILL_WORDS = 256;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode = MODE_TICK;
  logic signed [15:0] in_pitch = '0;
  logic [31:0]        in_fundamental = '0;
  logic               in_sync = 1'b0;
  logic [31:0]        in_phase_offset = '0;
  logic [15:0]        in_slice_select = '0;
  logic [13:0]        in_load_address = '0;
  logic signed [15:0] in_load_sample = '0;
  logic [13:0]        in_load_start = '0;
  logic [14:0]        in_load_length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample_out;
  logic [13:0]        out_read_position;
  logic [5:0]         out_active_slice;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_PERIOD;
  logic [31:0]        cfg_data = '0;

  sliced_wavetable_oscillator DUT (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [31:0]        p_period;
  logic [4:0]         p_span;
  logic [14:0]        p_length;
  logic [6:0]         p_slices;
  logic [31:0]        p_phase;
  logic signed [15:0] wave_mem [16384];
  logic [13:0]        seg_start [64];
  logic [14:0]        seg_len [64];

  osc_res_t awaited[$];
  int  n_err = 0, n_ticks = 0, n_loads = 0, n_cfg = 0, n_results = 0;
  bit  calm = 1'b0, stall_now = 1'b0, held = 1'b0;
  int  hold_left = 0;

  function automatic logic [31:0] phase_step(logic [31:0] fund, logic signed [15:0] pitch);
    longint       e;
    logic [31:0]  ue, f, t, m;
    int           ip;
    logic [127:0] full;
    e = longint'(pitch) * longint'(p_span);
    ue = 32'(e + (longint'(1) <<< 20));
    ip = int'(ue >> 15) - 32;
    f = ue & 32'h7fff;
    t = 32'd5156;
    t = 32'd14821 + ((t * f) >> 15);
    t = 32'd45559 + ((t * f) >> 15);
    m = 32'd65536 + ((t * f) >> 15);
    full = 128'(p_period) * 128'(fund) * 128'(m);
    return 32'(full >> (32 - ip));
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint seg_blend(logic [31:0] q, logic [13:0] st, logic [14:0] ln,
                                       output logic [13:0] first);
    logic [14:0] n;
    logic [63:0] p;
    logic [31:0] w;
    logic [13:0] a;
    n = (ln > 15'd16384) ? 15'd16384 : ln;
    n = (n != 0) ? n - 15'd1 : 15'd0;
    p = 64'(q) * 64'(n);
    w = 32'(p[31:16]);
    a = 14'(32'(st) + p[63:32]);
    first = a;
    return longint'(wave_mem[a]) * (longint'(65536) - longint'(w))
         + longint'(wave_mem[14'(a + 14'd1)]) * longint'(w);
  endfunction

  function automatic osc_res_t predict_output(osc_req_t r);
    osc_res_t    res;
    logic [31:0] q, t, mm, ws;
    logic [6:0]  cnt;
    logic [5:0]  lo;
    logic [13:0] first, other;
    longint      y, a, b;
    res = '0;
    case (r.mode)
      MODE_SAMPLE: wave_mem[r.addr] = r.smp;
      MODE_SLICE: if (r.addr < 64) begin
        seg_start[r.addr] = r.start;
        seg_len[r.addr] = r.len;
      end
      MODE_TICK: if (p_length != 0) begin
        p_phase = p_phase + phase_step(r.fund, r.pitch);
        if (r.sync) p_phase = '0;
        q = p_phase + r.offs;
        cnt = (p_slices > 7'd64) ? 7'd64 : p_slices;
        lo = '0;
        if (cnt == 0) begin
          y = round_sh(seg_blend(q, 14'd0, p_length, first), 16);
        end else if (cnt == 1) begin
          y = round_sh(seg_blend(q, seg_start[0], seg_len[0], first), 16);
        end else begin
          t = (r.sel > SELECT_MAX) ? 32'(SELECT_MAX) : 32'(r.sel);
          mm = t * 32'(cnt - 7'd1);
          lo = 6'(mm >> 16);
          ws = mm & 32'hffff;
          a = seg_blend(q, seg_start[lo], seg_len[lo], first);
          b = seg_blend(q, seg_start[lo + 6'd1], seg_len[lo + 6'd1], other);
          y = round_sh(a * (longint'(65536) - longint'(ws)) + b * longint'(ws), 32);
        end
        res.smp = 16'(y);
        res.pos = first;
        res.slc = lo;
      end
      default: ;
    endcase
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      osc_res_t want;
      n_results++;
      if (awaited.size() == 0) begin
        $error("unexpected result sample_out=%0d", out_sample_out);
        n_err++;
      end else begin
        want = awaited.pop_front();
        if (out_sample_out !== want.smp) begin
          $error("sample_out expected %0d got %0d", want.smp, out_sample_out);
          n_err++;
        end
        if (out_read_position !== want.pos) begin
          $error("read_position expected %0d got %0d", want.pos, out_read_position);
          n_err++;
        end
        if (out_active_slice !== want.slc) begin
          $error("active_slice expected %0d got %0d", want.slc, out_active_slice);
          n_err++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_now && !held) begin
      held <= 1'b1;
      hold_left <= 1500;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  task automatic send(osc_req_t r, bit typed, osc_res_t res);
    osc_res_t p;
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_pitch <= r.pitch;
    in_fundamental <= r.fund;
    in_sync <= r.sync;
    in_phase_offset <= r.offs;
    in_slice_select <= r.sel;
    in_load_address <= r.addr;
    in_load_sample <= r.smp;
    in_load_start <= r.start;
    in_load_length <= r.len;
    do @(posedge clk); while (!in_ready);
    p = predict_output(r);
    awaited.push_back(typed ? res : p);
    if (r.mode == MODE_TICK) n_ticks++;
    else n_loads++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] dat);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= dat;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PERIOD: p_period = dat;
      CFG_SPAN:   p_span = dat[4:0];
      CFG_LENGTH: p_length = dat[14:0];
      default:    p_slices = dat[6:0];
    endcase
    n_cfg++;
  endtask

  task automatic set_all(logic [31:0] per, logic [4:0] sp, logic [14:0] ln, logic [6:0] sc);
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_SPAN, 32'(sp));
    write_reg(CFG_LENGTH, 32'(ln));
    write_reg(CFG_SLICES, 32'(sc));
  endtask

  function automatic osc_req_t rand_req();
    osc_req_t r;
    int       k;
    r = '0;
    r.pitch = 16'($urandom);
    r.fund = $urandom_range(9) < 3 ? $urandom : $urandom_range(32'h0400_0000);
    r.sync = $urandom_range(9) == 0;
    r.offs = $urandom;
    r.sel = $urandom_range(9) == 0 ? 16'hffff : 16'($urandom);
    r.addr = 14'($urandom);
    r.smp = 16'($urandom);
    // slices stay inside the filled words, or start on the last word and wrap
    r.start = $urandom_range(9) == 0 ? 14'h3fff : 14'($urandom_range(127));
    r.len = 15'($urandom_range(128));
    k = $urandom_range(99);
    if (k < 72) r.mode = MODE_TICK;
    else if (k < 86) r.mode = MODE_SAMPLE;
    else if (k < 96) begin
      r.mode = MODE_SLICE;
      if ($urandom_range(4) != 0) r.addr = 14'($urandom_range(63));
    end else r.mode = MODE_UNUSED;
    return r;
  endfunction

  plan_row_t plan [$];

  function automatic plan_row_t tick_row(logic signed [15:0] pt, logic [31:0] fd, logic sy,
                                         logic [31:0] of, logic [15:0] sl);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.req.mode = MODE_TICK;
    row.req.pitch = pt;
    row.req.fund = fd;
    row.req.sync = sy;
    row.req.offs = of;
    row.req.sel = sl;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [1:0] idx, logic [31:0] dat);
    plan_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_dat = dat;
    return row;
  endfunction

  initial begin
    plan_row_t row;
    osc_req_t  r;
    int        ph;
    logic [31:0] per_tab [8];
    logic [4:0]  span_tab [8];
    logic [14:0] len_tab [8];
    logic [6:0]  cnt_tab [8];

    per_tab = '{32'd89478, 32'hffff_ffff, 32'd0, 32'd400000,
                32'd89478, 32'd1000, 32'd250000, 32'd89478};
    span_tab = '{5'd10, 5'd31, 5'd1, 5'd0, 5'd16, 5'd10, 5'd3, 5'd10};
    len_tab = '{15'd256, 15'd1, 15'd32767, 15'd0, 15'd300, 15'd16384, 15'd2, 15'd4096};
    cnt_tab = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd5, 7'd0, 7'd64};

    p_period = PERIOD_RST;
    p_span = SPAN_RST;
    p_length = '0;
    p_slices = '0;
    p_phase = '0;

    // directed table
    row = tick_row(16'sh7fff, 32'hffff_ffff, 1'b0, 32'h1234, 16'd0);
    row.typed = 1'b1;
    plan.push_back(row);
    row.req.mode = MODE_UNUSED;
    plan.push_back(row);
    row.req.mode = MODE_SLICE;
    row.req.addr = 14'h3fff;
    row.req.start = 14'h3fff;
    row.req.len = 15'h7fff;
    plan.push_back(row);
    row.req.mode = MODE_SAMPLE;
    row.req.addr = 14'h3fff;
    row.req.smp = 16'sh8000;
    plan.push_back(row);
    row = '0;
    row.kind = ROW_FILL;
    plan.push_back(row);
    plan.push_back(cfg_row(CFG_LENGTH, 32'(FILL_WORDS)));
    plan.push_back(tick_row(16'sh8000, 32'hffff_ffff, 1'b1, 32'h0, 16'd0));
    plan.push_back(tick_row(16'sh7fff, 32'h0370_0000, 1'b0, 32'hffff_ffff, 16'd0));
    plan.push_back(tick_row(16'sh0000, 32'h0000_0000, 1'b0, 32'h8000_0000, 16'd0));
    plan.push_back(tick_row(16'sh4000, 32'h01b8_0000, 1'b0, 32'h0, 16'd0));
    plan.push_back(cfg_row(CFG_SLICES, 32'd1));
    plan.push_back(tick_row(16'sh0000, 32'h01b8_0000, 1'b0, 32'h0, 16'd0));
    plan.push_back(cfg_row(CFG_SLICES, 32'd2));
    plan.push_back(tick_row(16'sh0000, 32'h01b8_0000, 1'b0, 32'h4000_0000, 16'd0));
    plan.push_back(tick_row(16'sh0000, 32'h01b8_0000, 1'b0, 32'h4000_0000, 16'hffff));
    plan.push_back(tick_row(16'sh0000, 32'h01b8_0000, 1'b0, 32'h4000_0000, 16'h8000));
    plan.push_back(cfg_row(CFG_SLICES, 32'd64));
    plan.push_back(tick_row(16'sh8000, 32'h0100_0000, 1'b0, 32'hc000_0000, 16'hfff9));
    plan.push_back(tick_row(16'sh7fff, 32'h0100_0000, 1'b1, 32'h0, 16'h7fff));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        ROW_CFG: write_reg(row.cfg_idx, row.cfg_dat);
        ROW_ITEM: send(row.req, row.typed, row.res);
        default: begin
          // low sample words and every slice entry are written before any tick reads them;
          // slices stay inside those words or wrap from the last word
          for (int a = 0; a < FILL_WORDS; a++) begin
            r = '0;
            r.mode = MODE_SAMPLE;
            r.addr = 14'(a);
            r.smp = (a == 1) ? 16'sh7fff : (a == 2) ? 16'sh8000 : 16'($urandom);
            send(r, 1'b1, ZERO_RES);
          end
          for (int a = 0; a < 64; a++) begin
            r = '0;
            r.mode = MODE_SLICE;
            r.addr = 14'(a);
            r.start = (a == 0) ? 14'h3fff : 14'($urandom_range(127));
            r.len = (a == 1) ? 15'd128 : 15'($urandom_range(128));
            send(r, 1'b1, ZERO_RES);
          end
        end
      endcase
    end

    // random phases, one register setting each
    for (ph = 0; ph < 8; ph++) begin
      set_all(per_tab[ph], span_tab[ph], len_tab[ph], cnt_tab[ph]);
      for (int k = 0; k < N_RANDOM / 8; k++) begin
        calm = (ph == 5);
        if (ph == 2 && k == 20) stall_now = 1'b1;
        r = rand_req();
        send(r, r.mode != MODE_TICK, ZERO_RES);
      end
      calm = 1'b0;
    end
    in_valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (awaited.size() != 0) begin
      $error("%0d results never arrived", awaited.size());
      n_err++;
    end
    $display("ran %0d ticks and %0d loads over %0d register writes", n_ticks, n_loads, n_cfg);
    $display("checked %0d results, %0d mismatches", n_results, n_err);
    if (n_err == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
